### rtl/srts_pkg.sv
package srts_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int TIME_BITS = 16;
	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam logic       CMD_LOAD     = 1'b0;
	localparam logic       CMD_TICK     = 1'b1;
	localparam logic       REG_ACTIVE   = 1'b0;
	localparam logic [4:0] ACTIVE_RESET = 5'd16;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  slot;
		logic [15:0] arrival;
		logic [15:0] burst;
	} item_t;

	typedef struct packed {
		logic [3:0]  chosen;
		logic        idle;
		logic        finished;
		logic [15:0] now;
	} result_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic update;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic item_tick;
		logic live_zero;
		logic scan_last;
	} dp_sts_t;

endpackage

### rtl/srts_cfg.sv
module srts_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  active_count
);
	import srts_pkg::*;

	logic [4:0] active_q;
	logic       wr_en;

	assign pready       = 1'b1;
	assign wr_en        = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE);
	assign active_count = active_q;
	assign prdata       = (paddr[2] == REG_ACTIVE) ? {27'b0, active_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (wr_en) begin
			active_q <= pwdata[4:0];
		end
	end

endmodule

### rtl/srts_dp.sv
module srts_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  srts_pkg::item_t   item,
	input  logic [4:0]        active_count,
	input  srts_pkg::dp_cmd_t c,
	output srts_pkg::dp_sts_t s,
	output srts_pkg::result_t result
);
	import srts_pkg::*;

	logic [TIME_BITS-1:0] arr_mem [MAX_SLOTS];
	logic [TIME_BITS-1:0] rem_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] nz_q;
	logic [TIME_BITS-1:0] clock_q;
	logic [SLOT_W-1:0]    cnt_q;

	logic                 rd_valid_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;
	logic                 rd_nz_s1;
	logic [TIME_BITS-1:0] rd_arr_s1;
	logic [TIME_BITS-1:0] rd_rem_s1;

	logic                 found_q;
	logic [TIME_BITS-1:0] min_q;
	logic [SLOT_W-1:0]    first_q;
	logic [SLOT_W-1:0]    last_q;
	logic [TIME_BITS-1:0] last_rem_q;
	result_t              result_q;

	logic [CNT_W-1:0]     live;
	logic [MAX_SLOTS-1:0] live_mask;
	logic                 done;
	logic                 ld_we;
	logic [SLOT_W-1:0]    ld_addr;
	logic                 up_we;
	logic [SLOT_W-1:0]    win;
	logic                 elig;
	logic                 take_min;

	always_comb begin
		if (32'(active_count) > 32'(MAX_SLOTS)) begin
			live = CNT_W'(MAX_SLOTS);
		end else begin
			live = CNT_W'(active_count);
		end
		for (int k = 0; k < MAX_SLOTS; k++) begin
			live_mask[k] = 32'(k) < 32'(live);
		end
	end

	assign done     = ~|(nz_q & live_mask);
	assign ld_we    = c.accept && (item.cmd == CMD_LOAD) && (32'(item.slot) < 32'(MAX_SLOTS));
	assign ld_addr  = SLOT_W'(item.slot);
	assign win      = (last_rem_q == min_q) ? last_q : first_q;
	assign up_we    = c.update && found_q;
	assign elig     = rd_valid_s1 && rd_nz_s1 && (clock_q >= rd_arr_s1);
	assign take_min = !found_q || (rd_rem_s1 < min_q);

	assign s.item_tick = (item.cmd == CMD_TICK);
	assign s.live_zero = (live == '0);
	assign s.scan_last = (CNT_W'(cnt_q) + CNT_W'(1)) == live;
	assign result      = result_q;

	// slot stores, one read port for the scan
	always_ff @(posedge clk) begin
		if (ld_we) begin
			arr_mem[ld_addr] <= TIME_BITS'(item.arrival);
			rem_mem[ld_addr] <= TIME_BITS'(item.burst);
		end else if (up_we) begin
			rem_mem[win] <= min_q - TIME_BITS'(1);
		end
		if (c.scan_step) begin
			rd_arr_s1 <= arr_mem[cnt_q];
			rd_rem_s1 <= rem_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q        <= '0;
			clock_q     <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= c.scan_step;
			if (ld_we) begin
				nz_q[ld_addr] <= TIME_BITS'(item.burst) != '0;
			end else if (up_we) begin
				nz_q[win] <= min_q != TIME_BITS'(1);
			end
			if (c.update && (clock_q != '1)) begin
				clock_q <= clock_q + TIME_BITS'(1);
			end
			if (c.accept) begin
				cnt_q <= '0;
			end else if (c.scan_step) begin
				cnt_q <= cnt_q + SLOT_W'(1);
			end
			if (c.accept) begin
				found_q <= 1'b0;
			end else if (elig) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c.scan_step) begin
			rd_idx_s1 <= cnt_q;
			rd_nz_s1  <= nz_q[cnt_q];
		end
		if (!c.accept && elig) begin
			if (take_min) begin
				min_q   <= rd_rem_s1;
				first_q <= rd_idx_s1;
			end
			last_q     <= rd_idx_s1;
			last_rem_q <= rd_rem_s1;
		end
		if (c.out_load) begin
			result_q.chosen   <= found_q ? 4'(win) : 4'd0;
			result_q.idle     <= !found_q;
			result_q.finished <= done;
			result_q.now      <= 16'(clock_q);
		end
	end

	a_win_live: assert property (@(posedge clk) disable iff (!arst_n)
		up_we |-> nz_q[win])
		else $error("winner slot has no remaining time");

	a_clock_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!c.update |=> $stable(clock_q))
		else $error("clock moved outside a tick update");

endmodule

### rtl/srts_ctrl.sv
module srts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  srts_pkg::dp_sts_t s,
	output srts_pkg::dp_cmd_t c
);
	import srts_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       result_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	assign c.accept    = item_ready && item_valid;
	assign c.scan_step = (state_q == S_SCAN);
	assign c.update    = (state_q == S_UPD);
	assign c.out_load  = (state_q == S_OUT) && (!result_valid_q || result_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (c.accept) begin
					if (!s.item_tick) begin
						state_d = S_OUT;
					end else if (s.live_zero) begin
						state_d = S_UPD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (s.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (c.out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (c.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !s.live_zero)
		else $error("scan running with no live slots");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		c.accept |=> !item_ready)
		else $error("new beat taken while previous one in progress");

endmodule

### rtl/shortest_remaining_time_scheduler.sv
// Loads go straight to the output state; ticks scan N slots, then drain, update and output.
// N = active slots clamped to 16; N = 0 skips scan and drain; scan reads one slot per cycle.
// One beat in flight; the output state waits only while the previous result still waits at
// its output, and the next beat is taken while a result waits there.
// Async active-low reset clears clock, remaining-time valid bits and control;
// active_count resets to 16.
module shortest_remaining_time_scheduler (
	input  logic              clk,
	input  logic              arst_n,
	input  srts_pkg::item_t   item,
	input  logic              item_valid,
	output logic              item_ready,
	output srts_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_ready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import srts_pkg::*;

	logic [4:0] active_count;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	srts_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.active_count (active_count)
	);

	srts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.s            (sts),
		.c            (cmd)
	);

	srts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.active_count (active_count),
		.c            (cmd),
		.s            (sts),
		.result       (result)
	);

endmodule

### dv/srts_checker.sv
`timescale 1ns / 1ps

module srts_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  srts_pkg::item_t   item,
	input  logic              item_valid,
	input  logic              item_ready,
	input  srts_pkg::result_t result,
	input  logic              result_valid,
	input  logic              result_ready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                pending
);
	import srts_pkg::*;

	localparam logic [2:0] ACTIVE_ADDR = 3'(REG_ACTIVE) << 2;

	logic [TIME_BITS-1:0] arrival_mem [MAX_SLOTS];
	logic [TIME_BITS-1:0] remain_mem [MAX_SLOTS];
	logic [TIME_BITS-1:0] clock_now;
	logic [4:0]           active_cnt;
	result_t              sched_q [$];
	result_t              want;
	int                   mismatches;

	function automatic bit runnable(int k);
		return remain_mem[k] != 0 && clock_now >= arrival_mem[k];
	endfunction

	function automatic result_t schedule_beat(item_t beat);
		result_t r;
		int      live;
		int      best;
		bit      found;
		bit      done;
		r = '0;
		r.idle = 1'b1;
		live = (active_cnt > MAX_SLOTS) ? MAX_SLOTS : int'(active_cnt);
		if (beat.cmd == CMD_LOAD) begin
			arrival_mem[beat.slot] = beat.arrival;
			remain_mem[beat.slot] = beat.burst;
		end else begin
			found = 1'b0;
			best = 0;
			for (int k = 0; k < live; k++)
				if (runnable(k)) begin
					best = k;
					found = 1'b1;
				end
			if (found) begin
				// highest eligible keeps the slot only if it holds the minimum
				for (int k = 0; k < live; k++)
					if (runnable(k) && remain_mem[k] < remain_mem[best])
						best = k;
				remain_mem[best] = remain_mem[best] - 1'b1;
				r.chosen = best[3:0];
				r.idle = 1'b0;
			end
			if (clock_now != '1)
				clock_now = clock_now + 1'b1;
		end
		done = 1'b1;
		for (int k = 0; k < live; k++)
			if (remain_mem[k] != 0)
				done = 1'b0;
		r.finished = done;
		r.now = clock_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SLOTS; k++) begin
				arrival_mem[k] = '0;
				remain_mem[k] = '0;
			end
			clock_now = '0;
			active_cnt = ACTIVE_RESET;
			sched_q.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (sched_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: chosen=%0d idle=%0b finished=%0b now=%0d",
							result.chosen, result.idle, result.finished, result.now);
				end else begin
					want = sched_q.pop_front();
					if (result.chosen !== want.chosen || result.idle !== want.idle ||
							result.finished !== want.finished || result.now !== want.now) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: exp chosen=%0d idle=%0b finished=%0b now=%0d %s",
								want.chosen, want.idle, want.finished, want.now,
								$sformatf("got chosen=%0d idle=%0b finished=%0b now=%0d",
									result.chosen, result.idle, result.finished, result.now));
					end
				end
			end
			if (item_valid && item_ready)
				sched_q.push_back(schedule_beat(item));
			if (psel && penable && pwrite && pready && paddr == ACTIVE_ADDR)
				active_cnt = pwdata[4:0];
			fail_count <= mismatches;
			pending <= sched_q.size();
		end
	end

endmodule

### dv/shortest_remaining_time_scheduler_test.sv
`timescale 1ns / 1ps

module shortest_remaining_time_scheduler_test;
	import srts_pkg::*;

	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         SETTLE_CYCLES  = 24;
	localparam int         CLOCK_MAX      = 65535;
	localparam logic [2:0] ACTIVE_ADDR    = 3'(REG_ACTIVE) << 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	item_t       item = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	result_t     result;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int clock_est = 0;

	logic [4:0] phase_cnt [13] = '{5'd1, 5'd16, 5'd5, 5'd0, 5'd2, 5'd20, 5'd9, 5'd16,
		5'd31, 5'd3, 5'd12, 5'd16, 5'd7};

	always #5 clk = ~clk;

	shortest_remaining_time_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	srts_checker sched_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(psel && penable && pwrite && pready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic int draw_wait();
		return int'($urandom_range(0, 19));
	endfunction

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_wait();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	task automatic send_beat(item_t beat);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && item_ready));
		if (beat.cmd == CMD_TICK && clock_est < CLOCK_MAX)
			clock_est++;
	endtask

	task automatic load_slot(logic [3:0] s, logic [15:0] arr, logic [15:0] len);
		item_t beat;
		beat.cmd = CMD_LOAD;
		beat.slot = s;
		beat.arrival = arr;
		beat.burst = len;
		send_beat(beat);
	endtask

	task automatic run_tick();
		item_t beat;
		beat.cmd = CMD_TICK;
		beat.slot = 4'($urandom);
		beat.arrival = 16'($urandom);
		beat.burst = 16'($urandom);
		send_beat(beat);
	endtask

	// hold the sender until every result is back and the block has settled
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active(logic [4:0] cnt);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACTIVE_ADDR;
		pwdata <= 32'(cnt);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// loads first, then ticks with late arrivals mixed in
	task automatic random_phase(logic [4:0] cnt, int beats);
		int          live;
		int          opening;
		int          pick;
		logic [3:0]  s;
		logic [15:0] arr;
		logic [15:0] len;
		write_active(cnt);
		live = (cnt == 0) ? 1 : ((cnt > MAX_SLOTS) ? MAX_SLOTS : int'(cnt));
		opening = $urandom_range(2, 5);
		for (int n = 0; n < beats; n++) begin
			if (n < opening || $urandom_range(0, 99) < 20) begin
				s = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, live - 1));
				case ($urandom_range(0, 9))
					0: arr = 16'($urandom);
					1: arr = '0;
					default: arr = 16'(clock_est + $urandom_range(0, 10));
				endcase
				pick = $urandom_range(0, 19);
				len = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 6));
				load_slot(s, arr, len);
			end else begin
				run_tick();
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_tick();
		load_slot(4'd0, 16'd0, 16'd3);
		load_slot(4'd15, 16'd0, 16'd3);
		load_slot(4'd7, 16'hFFFF, 16'hFFFF);
		load_slot(4'd9, 16'd0, 16'd0);
		run_tick();
		run_tick();
		load_slot(4'd2, 16'd5, 16'd1);
		run_tick();
		run_tick();
		run_tick();
		load_slot(4'd4, 16'd0, 16'd2);
		load_slot(4'd11, 16'd0, 16'd2);
		load_slot(4'd13, 16'd0, 16'd5);
		run_tick();
		load_slot(4'd7, 16'd0, 16'd0);
		repeat (4) run_tick();

		foreach (phase_cnt[i])
			random_phase(phase_cnt[i], 35);

		write_active(5'd16);
		load_slot(4'd7, 16'hFFFF, 16'd3);
		load_slot(4'd12, 16'hFFFE, 16'd3);
		load_slot(4'd14, 16'hFFFF, 16'hFFFF);
		repeat (8) run_tick();

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
